// File: rtl/awbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awbb_pkg
// Shared types and constants of the alpha-weighted 5x5 box blur.
// ----------------------------------------------------------------------------
package awbb_pkg;

  localparam int WIN = 5;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pix_t;

  typedef pix_t [WIN-1:0] col_t;

  // masked sums of one window column
  typedef struct packed {
    logic [2:0]  n;
    logic [10:0] a;
    logic [18:0] r;
    logic [18:0] g;
    logic [18:0] b;
  } csum_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SUM,
    S_ADD,
    S_DSTART,
    S_DIV,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// File: rtl/awbb_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awbb_bank
// One line store: a row of packed pixels, read before write at one address.
// ----------------------------------------------------------------------------
module awbb_bank #(
  parameter int DEPTH = 4096
) (
  input  wire                             clk,
  input  wire                             rd_en,
  input  wire                             wr_en,
  input  wire [$clog2(DEPTH)-1:0]         addr,
  input  awbb_pkg::pix_t                  wr_data,
  output awbb_pkg::pix_t                  rd_data_r
);
  import awbb_pkg::*;

  pix_t mem [DEPTH];

  // old word comes out when the same address is written
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/awbb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awbb_cell
// One window column: holds five pixels, passes them to its neighbour on a
// shift and forms the masked alpha and weighted colour sums of the column.
// ----------------------------------------------------------------------------
module awbb_cell (
  input  wire                    clk,
  input  wire                    shift_en,
  input  wire                    calc_en,
  input  awbb_pkg::col_t         col_in,
  input  wire [awbb_pkg::WIN-1:0] row_ok,
  input  wire                    col_ok,
  output awbb_pkg::col_t         col_r,
  output awbb_pkg::csum_t        sum_r
);
  import awbb_pkg::*;

  csum_t sum_nxt;

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < WIN; i++) begin
      if (row_ok[i] && col_ok) begin
        sum_nxt.n = sum_nxt.n + 3'd1;
        sum_nxt.a = sum_nxt.a + 11'(col_r[i].a);
        sum_nxt.r = sum_nxt.r + 19'({8'd0, col_r[i].r} * {8'd0, col_r[i].a});
        sum_nxt.g = sum_nxt.g + 19'({8'd0, col_r[i].g} * {8'd0, col_r[i].a});
        sum_nxt.b = sum_nxt.b + 19'({8'd0, col_r[i].b} * {8'd0, col_r[i].a});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
    if (calc_en) begin
      sum_r <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/awbb_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awbb_div
// Restoring divider, one quotient bit a cycle, eight-bit quotient.
// ----------------------------------------------------------------------------
module awbb_div (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  input  wire [20:0] dividend,
  input  wire [12:0] divisor,
  output logic [7:0] quot_r,
  output logic       done_r
);
  logic [20:0] rem_r;
  logic [20:0] dsh_r;
  logic [2:0]  step_r;
  logic        busy_r;
  logic        take;

  assign take = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 3'd7;
      end else if (busy_r) begin
        step_r <= step_r - 3'd1;
        if (step_r == 3'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      dsh_r  <= {1'b0, divisor, 7'd0};
      quot_r <= '0;
    end else if (busy_r) begin
      if (take) begin
        rem_r <= rem_r - dsh_r;
      end
      quot_r <= {quot_r[6:0], take};
      dsh_r  <= {1'b0, dsh_r[20:1]};
    end
  end

endmodule
`default_nettype wire

// File: rtl/alpha_weighted_box_blur_5x5_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: a pixel that yields a result passes S_LOAD, S_SUM, S_ADD, S_DSTART,
//   S_DIV (four separate eight-step divider lanes) and S_OUT; the next pixel
//   is taken only back in S_IDLE, and S_OUT waits while a result is unaccepted.
// Pixels of the first 2*width+2 of a frame yield no result and pass S_LOAD only.
// Reset (rst_n, synchronous): counters clear, width 640, height 480; the line
//   stores are not cleared.
// ----------------------------------------------------------------------------
// alpha_weighted_box_blur_5x5_unit
// Alpha-weighted 5x5 box blur over an RGBA raster with four line stores.
// ----------------------------------------------------------------------------
module alpha_weighted_box_blur_5x5_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [1:0]  cfg_index,
  input  wire [15:0] cfg_data,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [7:0]  in_red_in,
  input  wire [7:0]  in_green_in,
  input  wire [7:0]  in_blue_in,
  input  wire [7:0]  in_alpha_in,
  input  wire        in_pad,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic [7:0] out_alpha_out,
  output logic       out_frame_end
);
  import awbb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int TW = $clog2(2 * MAX_WIDTH + 3);

  state_t state_r, state_nxt;

  logic [12:0]   img_w_r;
  logic [15:0]   img_h_r;
  logic [WW-1:0] weff;
  logic [15:0]   heff;
  logic [TW-1:0] thr;

  logic [CW-1:0] in_col_r;
  logic [1:0]    slot_r;
  logic [TW-1:0] cnt_r;
  logic [CW-1:0] out_col_r;
  logic [15:0]   out_row_r;

  logic          in_acc, cfg_acc, warm, fend, in_last;
  pix_t          pix;

  pix_t          pix_c_r;
  logic [1:0]    slot_c_r;
  logic          warm_c_r, fend_c_r;
  logic [CW-1:0] ocol_c_r;
  logic [15:0]   orow_c_r;

  pix_t          bank_rd [4];
  col_t          new_col;
  col_t          cell_col [WIN];
  csum_t         cell_sum [WIN];
  logic [WIN-1:0] row_ok, col_ok;
  logic          shift_en, calc_en, div_start, out_load;

  logic [4:0]    tot_n, tot_n_r;
  logic [12:0]   tot_a, tot_a_r;
  logic [20:0]   tot_r, tot_g, tot_b, tot_r_r, tot_g_r, tot_b_r;
  logic [7:0]    q_r, q_g, q_b, q_a;
  logic          d_r, d_g, d_b, d_a;

  logic          out_valid_r;
  logic [7:0]    red_r, green_r, blue_r, alpha_r;
  logic          fe_r;

  // effective frame size
  always_comb begin
    logic [16:0] w17;
    w17 = {4'd0, img_w_r};
    if (w17 == 17'd0) begin
      weff = WW'(1);
    end else if (w17 > 17'(MAX_WIDTH)) begin
      weff = WW'(MAX_WIDTH);
    end else begin
      weff = WW'(w17);
    end
    heff = (img_h_r == 16'd0) ? 16'd1 : img_h_r;
  end

  assign thr       = TW'({weff, 1'b0}) + TW'(2);
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign warm      = (cnt_r >= thr);
  assign fend      = (out_row_r == heff - 16'd1) && (WW'(out_col_r) == weff - WW'(1));
  assign in_last   = (WW'(in_col_r) == weff - WW'(1));
  assign pix       = in_pad ? pix_t'('0) : pix_t'{a: in_alpha_in, b: in_blue_in,
                                                 g: in_green_in, r: in_red_in};

  // configuration and raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r   <= 13'd640;
      img_h_r   <= 16'd480;
      in_col_r  <= '0;
      slot_r    <= '0;
      cnt_r     <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_acc) begin
      if (cfg_index == CFG_IMAGE_WIDTH) begin
        img_w_r <= cfg_data[12:0];
      end
      if (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT) begin
        in_col_r  <= '0;
        slot_r    <= '0;
        cnt_r     <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end
      if (cfg_index == CFG_IMAGE_HEIGHT) begin
        img_h_r <= cfg_data;
      end
    end else if (in_acc) begin
      if (warm && fend) begin
        in_col_r  <= '0;
        slot_r    <= '0;
        cnt_r     <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        if (in_last) begin
          in_col_r <= '0;
          slot_r   <= slot_r + 2'd1;
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
        if (!warm) begin
          cnt_r <= cnt_r + TW'(1);
        end else if (WW'(out_col_r) == weff - WW'(1)) begin
          out_col_r <= '0;
          out_row_r <= out_row_r + 16'd1;
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end
    end
  end

  // hold the accepted word for the window stages
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_c_r  <= pix;
      slot_c_r <= slot_r;
      warm_c_r <= warm;
      fend_c_r <= fend;
      ocol_c_r <= out_col_r;
      orow_c_r <= out_row_r;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_bank
    awbb_bank #(.DEPTH(MAX_WIDTH)) u_bank (
      .clk       (clk),
      .rd_en     (in_acc),
      .wr_en     (in_acc && (slot_r == 2'(k))),
      .addr      (in_col_r),
      .wr_data   (pix),
      .rd_data_r (bank_rd[k])
    );
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      new_col[i] = bank_rd[slot_c_r + 2'(i)];
    end
    new_col[4] = pix_c_r;
  end

  // window edge masks
  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      row_ok[i] = ({2'd0, orow_c_r} + 18'(i) >= 18'd2) &&
                  ({2'd0, orow_c_r} + 18'(i) < {2'd0, heff} + 18'd2);
      col_ok[i] = (18'(ocol_c_r) + 18'(i) >= 18'd2) &&
                  (18'(ocol_c_r) + 18'(i) < 18'(weff) + 18'd2);
    end
  end

  for (genvar j = 0; j < WIN; j++) begin : g_cell
    awbb_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .calc_en  (calc_en),
      .col_in   ((j == WIN - 1) ? new_col : cell_col[(j + 1) % WIN]),
      .row_ok   (row_ok),
      .col_ok   (col_ok[j]),
      .col_r    (cell_col[j]),
      .sum_r    (cell_sum[j])
    );
  end

  always_comb begin
    tot_n = '0;
    tot_a = '0;
    tot_r = '0;
    tot_g = '0;
    tot_b = '0;
    for (int j = 0; j < WIN; j++) begin
      tot_n = tot_n + 5'(cell_sum[j].n);
      tot_a = tot_a + 13'(cell_sum[j].a);
      tot_r = tot_r + 21'(cell_sum[j].r);
      tot_g = tot_g + 21'(cell_sum[j].g);
      tot_b = tot_b + 21'(cell_sum[j].b);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ADD) begin
      tot_n_r <= tot_n;
      tot_a_r <= tot_a;
      tot_r_r <= tot_r;
      tot_g_r <= tot_g;
      tot_b_r <= tot_b;
    end
  end

  awbb_div u_div_r (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(tot_r_r),
                    .divisor(tot_a_r), .quot_r(q_r), .done_r(d_r));
  awbb_div u_div_g (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(tot_g_r),
                    .divisor(tot_a_r), .quot_r(q_g), .done_r(d_g));
  awbb_div u_div_b (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(tot_b_r),
                    .divisor(tot_a_r), .quot_r(q_b), .done_r(d_b));
  awbb_div u_div_a (.clk(clk), .rst_n(rst_n), .start(div_start),
                    .dividend({8'd0, tot_a_r}), .divisor({8'd0, tot_n_r}),
                    .quot_r(q_a), .done_r(d_a));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    shift_en  = 1'b0;
    calc_en   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        shift_en  = 1'b1;
        state_nxt = warm_c_r ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        calc_en   = 1'b1;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (d_a) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_r   <= (tot_a_r == 13'd0) ? 8'd0 : q_r;
      green_r <= (tot_a_r == 13'd0) ? 8'd0 : q_g;
      blue_r  <= (tot_a_r == 13'd0) ? 8'd0 : q_b;
      alpha_r <= q_a;
      fe_r    <= fend_c_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;
  assign out_alpha_out = alpha_r;
  assign out_frame_end = fe_r;

  a_div_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    d_a |-> (d_r && d_g && d_b && state_r == S_DIV))
    else $error("divider lanes out of step");

  a_warmup_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_acc |-> cnt_r <= thr)
    else $error("warm-up count beyond threshold");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(in_col_r) < weff)
    else $error("input column beyond width");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> tot_n_r != 5'd0)
    else $error("empty window on result");

endmodule
`default_nettype wire

// File: tb/awbb_blur_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awbb_blur_checker
// Watches the configuration, pixel and result channels of the blur unit,
// predicts each blurred pixel from its own window and line stores, and
// compares every result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module awbb_blur_checker #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_valid,
  input  wire        cfg_ready,
  input  wire [1:0]  cfg_index,
  input  wire [15:0] cfg_data,
  input  wire        in_valid,
  input  wire        in_ready,
  input  wire [7:0]  in_red_in,
  input  wire [7:0]  in_green_in,
  input  wire [7:0]  in_blue_in,
  input  wire [7:0]  in_alpha_in,
  input  wire        in_pad,
  input  wire        out_valid,
  input  wire        out_ready,
  input  wire [7:0]  out_red_out,
  input  wire [7:0]  out_green_out,
  input  wire [7:0]  out_blue_out,
  input  wire [7:0]  out_alpha_out,
  input  wire        out_frame_end,
  output int         mismatches,
  output int         outstanding,
  output int         blurred_seen,
  output int         frames_seen
);
  import awbb_pkg::*;

  typedef struct {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       fend;
  } blurred_t;

  blurred_t   blurred_q[$];
  pix_t       line_mem[4*MAX_WIDTH];
  pix_t       win[5][5];
  logic [12:0] width_reg;
  logic [15:0] height_reg;
  int         in_col, in_row, out_col, out_row;

  assign outstanding = blurred_q.size();

  task automatic restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic blur_pixel(input pix_t px);
    int w, h, c, slot, idx, v, u, cnt;
    int asum, rsum, gsum, bsum;
    pix_t colv[5];
    pix_t p;
    blurred_t e;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
    h = (height_reg == 0) ? 1 : int'(height_reg);
    c = (in_col >= w) ? w - 1 : in_col;
    slot = in_row & 3;
    for (int i = 0; i < 4; i++) colv[i] = line_mem[((slot + i) & 3) * MAX_WIDTH + c];
    colv[4] = px;
    line_mem[slot * MAX_WIDTH + c] = px;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) win[i][j] = win[i][j+1];
      win[i][4] = colv[i];
    end
    idx = in_row * w + c;
    in_col = c + 1;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    // still filling the line stores
    if (idx < 2 * w + 2) return;
    cnt = 0; asum = 0; rsum = 0; gsum = 0; bsum = 0;
    for (int i = 0; i < 5; i++) begin
      v = out_row - 2 + i;
      if (v < 0 || v >= h) continue;
      for (int j = 0; j < 5; j++) begin
        u = out_col - 2 + j;
        if (u < 0 || u >= w) continue;
        p = win[i][j];
        asum += p.a;
        rsum += p.r * p.a;
        gsum += p.g * p.a;
        bsum += p.b * p.a;
        cnt++;
      end
    end
    e.a = (cnt != 0) ? 8'(asum / cnt) : 8'd0;
    e.r = (asum != 0) ? 8'(rsum / asum) : 8'd0;
    e.g = (asum != 0) ? 8'(gsum / asum) : 8'd0;
    e.b = (asum != 0) ? 8'(bsum / asum) : 8'd0;
    e.fend = (out_row == h - 1) && (out_col == w - 1);
    blurred_q.push_back(e);
    if (e.fend) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  always @(posedge clk) begin
    blurred_t e;
    pix_t px;
    int errs;
    errs = 0;
    if (!rst_n) begin
      width_reg  = 13'd640;
      height_reg = 16'd480;
      for (int i = 0; i < 5; i++)
        for (int j = 0; j < 5; j++) win[i][j] = '0;
      restart_frame();
      blurred_q.delete();
      mismatches   <= 0;
      blurred_seen <= 0;
      frames_seen  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IMAGE_WIDTH) begin
          width_reg = cfg_data[12:0];
          restart_frame();
        end else if (cfg_index == CFG_IMAGE_HEIGHT) begin
          height_reg = cfg_data;
          restart_frame();
        end
      end
      if (in_valid && in_ready) begin
        px = in_pad ? pix_t'('0)
                    : pix_t'({in_alpha_in, in_blue_in, in_green_in, in_red_in});
        blur_pixel(px);
      end
      if (out_valid && out_ready) begin
        blurred_seen <= blurred_seen + 1;
        if (out_frame_end) frames_seen <= frames_seen + 1;
        if (blurred_q.size() == 0) begin
          $error("unexpected result word");
          errs = 1;
        end else begin
          e = blurred_q.pop_front();
          if (out_red_out !== e.r) begin
            $error("red_out: expected %0d, got %0d", e.r, out_red_out);
            errs++;
          end
          if (out_green_out !== e.g) begin
            $error("green_out: expected %0d, got %0d", e.g, out_green_out);
            errs++;
          end
          if (out_blue_out !== e.b) begin
            $error("blue_out: expected %0d, got %0d", e.b, out_blue_out);
            errs++;
          end
          if (out_alpha_out !== e.a) begin
            $error("alpha_out: expected %0d, got %0d", e.a, out_alpha_out);
            errs++;
          end
          if (out_frame_end !== e.fend) begin
            $error("frame_end: expected %0d, got %0d", e.fend, out_frame_end);
            errs++;
          end
        end
        mismatches <= mismatches + errs;
      end
    end
  end

endmodule

// File: tb/tb_alpha_weighted_box_blur_5x5_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alpha_weighted_box_blur_5x5_unit
// Streams directed and random RGBA frames of many sizes through the blur
// unit with bursty input, random output stalls and one long back-pressure
// stretch; the checker beside the unit predicts and compares every word.
// ----------------------------------------------------------------------------
module tb_alpha_weighted_box_blur_5x5_unit;
  import awbb_pkg::*;

  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;
  localparam int         CYCLE_LIMIT = 3000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_red_in = '0, in_green_in = '0, in_blue_in = '0, in_alpha_in = '0;
  logic        in_pad = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red_out, out_green_out, out_blue_out, out_alpha_out;
  logic        out_frame_end;

  int mismatches, outstanding, blurred_seen, frames_seen;
  int pixels_sent = 0;
  int burst_left = 0;
  int cycles = 0;
  int rand_pixels = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  alpha_weighted_box_blur_5x5_unit u_dut (.*);

  awbb_blur_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stalls, quiet stretches, and one long hold-off
  initial begin
    int hold;
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && pixels_sent > 200) begin
        held = 1;
        out_ready <= 1'b0;
        for (hold = 0; hold < 600; hold++) @(posedge clk);
      end
      if ((cycles / 2000) % 3 == 0) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // let the unit go quiet before touching its registers
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic push(input logic [7:0] r, g, b, a, input logic pad);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 20);
    end
    in_valid    <= 1'b1;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    in_alpha_in <= a;
    in_pad      <= pad;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    pixels_sent++;
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_pads(input int n);
    for (int k = 0; k < n; k++)
      push(rnd8(), rnd8(), rnd8(), rnd8(), 1'b1);
  endtask

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return rnd8();
    endcase
  endfunction

  initial begin
    int w, h, n, style;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, mid-frame pad, zero alpha everywhere
    cfg_write(CFG_IMAGE_WIDTH, 16'd3);
    cfg_write(CFG_IMAGE_HEIGHT, 16'd2);
    push(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    push(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    push(8'd255, 8'd0, 8'd128, 8'd1, 1'b0);
    push(8'd77, 8'd200, 8'd13, 8'd255, 1'b1);
    push(8'd0, 8'd255, 8'd0, 8'd254, 1'b0);
    push(8'd1, 8'd2, 8'd3, 8'd128, 1'b0);
    push_pads(8);
    drain();
    cfg_write(CFG_IMAGE_WIDTH, 16'd1);
    cfg_write(CFG_IMAGE_HEIGHT, 16'd1);
    push(8'd255, 8'd255, 8'd255, 8'd0, 1'b0);
    push_pads(4);
    drain();
    // zero size is taken as one
    cfg_write(CFG_IMAGE_WIDTH, 16'd0);
    cfg_write(CFG_IMAGE_HEIGHT, 16'd0);
    push(8'd200, 8'd100, 8'd50, 8'd255, 1'b0);
    push_pads(4);
    drain();
    // writes to unused indexes change nothing
    cfg_write(CFG_SPARE_A, 16'hFFFF);
    cfg_write(CFG_SPARE_B, 16'h5A5A);
    push(8'd9, 8'd8, 8'd7, 8'd6, 1'b0);
    push_pads(4);
    drain();

    // random frames, some broken or without flush
    while (rand_pixels < 300) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      h = $urandom_range(1, 6);
      cfg_write(CFG_IMAGE_WIDTH, 16'(w));
      cfg_write(CFG_IMAGE_HEIGHT, 16'(h));
      style = $urandom_range(0, 9);
      for (int f = 0; f < $urandom_range(1, 2); f++) begin
        for (int k = 0; k < w * h; k++) begin
          push(rnd8(), rnd8(), rnd8(), pick_alpha(),
               (style == 0) && ($urandom_range(0, 7) == 0));
          rand_pixels++;
        end
        if (style == 1) n = $urandom_range(0, 2 * w + 1);
        else if (style == 2) n = 2 * w + 2 + $urandom_range(1, 5);
        else n = 2 * w + 2;
        push_pads(n);
      end
      drain();
    end

    // tall frame cut short, then a short run at an oversize width
    cfg_write(CFG_IMAGE_WIDTH, 16'd2);
    cfg_write(CFG_IMAGE_HEIGHT, 16'hFFFF);
    for (int k = 0; k < 24; k++)
      push(rnd8(), rnd8(), rnd8(), pick_alpha(), 1'b0);
    drain();
    cfg_write(CFG_IMAGE_WIDTH, 16'h1FFF);
    cfg_write(CFG_IMAGE_HEIGHT, 16'd1);
    for (int k = 0; k < 40; k++)
      push(rnd8(), rnd8(), rnd8(), pick_alpha(), 1'b0);

    drain();
    $display("Sent %0d pixel words (%0d in random frames), checked %0d blurred words",
             pixels_sent, rand_pixels, blurred_seen);
    $display("across %0d completed frames with %0d mismatches", frames_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: alpha_weighted_box_blur_5x5_unit.f
rtl/awbb_pkg.sv
rtl/awbb_bank.sv
rtl/awbb_cell.sv
rtl/awbb_div.sv
rtl/alpha_weighted_box_blur_5x5_unit.sv
tb/awbb_blur_checker.sv
tb/tb_alpha_weighted_box_blur_5x5_unit.sv
